// File: design/yt_pkg.sv
// shared types and constants for the young tableau priority queue
// no dependencies

package yt_pkg;

  localparam int KEY_W  = 32;
  localparam int HELD_W = 7;

  localparam logic signed [KEY_W-1:0] KEY_EMPTY = 32'sh7FFF_FFFF;
  localparam logic signed [KEY_W-1:0] KEY_MIN   = 32'sh8000_0000;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HEAD,
    S_UP,
    S_DOWN,
    S_DONE
  } fsm_t;

  // outcome of one sift step
  typedef struct packed {
    logic                     move;
    logic                     pick_b;
    logic signed [KEY_W-1:0]  value;
  } step_t;

endpackage

// File: design/yt_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module yt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/yt_step.sv
// one sift step: compares the carried key with its two neighbours
// depends on yt_pkg

module yt_step import yt_pkg::*; (
  input  logic                     up_mode,
  input  logic signed [KEY_W-1:0]  key,
  input  logic signed [KEY_W-1:0]  nb_a,
  input  logic signed [KEY_W-1:0]  nb_b,
  input  logic                     a_ok,
  input  logic                     b_ok,
  output step_t                    step
);

  logic signed [KEY_W-1:0] va;
  logic signed [KEY_W-1:0] vb;
  logic signed [KEY_W-1:0] best;
  logic                    take_a;
  logic                    take_b;

  // up: a is the upper cell, b the left one; down: a is right, b is below
  always_comb begin
    va     = a_ok ? nb_a : (up_mode ? KEY_MIN : KEY_EMPTY);
    vb     = b_ok ? nb_b : (up_mode ? KEY_MIN : KEY_EMPTY);
    take_a = up_mode ? (key < va) : (key > va);
    best   = take_a ? va : key;
    take_b = up_mode ? (best < vb) : (best > vb);
    step.move   = take_a | take_b;
    step.pick_b = take_b;
    step.value  = take_b ? vb : va;
  end

endmodule

// File: design/young_tableau_priority_queue.sv
// top level of the young tableau priority queue
// depends on yt_pkg, yt_ram and yt_step
//
//   channel  | ports                                   | direction
//   ---------+-----------------------------------------+----------
//   in       | in_valid in_ready in_op in_key          | in
//   out      | out_valid out_ready out_min_value       | out
//            | out_status out_held                     |
//
// an insert sifts its key up from the bottom-right cell, then posts the result; an
// extract first fetches the top-left key, then sifts down. one sift step a cycle,
// set by the single read of both neighbours from the duplicated cell memory.
// refused or ignored requests skip the sift. after reset a clearing pass writes
// the empty marker into all ROWS*COLS cells, one a cycle, before in_ready rises.
// the result register lets a new item be taken while the last result waits.

module young_tableau_priority_queue import yt_pkg::*; #(
  parameter int ROWS = 8,
  parameter int COLS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_op,
  input  logic signed [KEY_W-1:0]  in_key,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [KEY_W-1:0]  out_min_value,
  output logic [1:0]               out_status,
  output logic [HELD_W-1:0]        out_held
);

  localparam int NCELLS = ROWS * COLS;
  localparam int AW     = $clog2(NCELLS);
  localparam int RW     = $clog2(ROWS);
  localparam int CW     = $clog2(COLS);
  localparam int CNTW   = $clog2(NCELLS + 1);

  // control state
  fsm_t            state_r, state_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic            out_valid_r;

  // sift position and carried key
  logic [AW-1:0]           pos_r, pos_nxt;
  logic [RW-1:0]           row_r, row_nxt;
  logic [CW-1:0]           col_r, col_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;

  // pending result
  logic signed [KEY_W-1:0] res_min_r, res_min_nxt;
  logic [1:0]              res_stat_r, res_stat_nxt;

  // output register
  logic signed [KEY_W-1:0] out_min_r;
  logic [1:0]              out_stat_r;
  logic [HELD_W-1:0]       out_held_r;

  // memory ports
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [KEY_W-1:0] ram_wdata;
  logic [AW-1:0]   raddr_a, raddr_b;
  logic [KEY_W-1:0] rdata_a, rdata_b;

  logic  in_xfer;
  logic  out_free;
  logic  is_full;
  logic  is_empty;
  logic  load_out;
  logic  up_mode;
  logic  a_ok, b_ok;
  step_t step;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid & in_ready;
  assign out_free = ~out_valid_r | out_ready;
  assign load_out = (state_r == S_DONE) & out_free;
  assign is_full  = (count_r == CNTW'(NCELLS));
  assign is_empty = (count_r == '0);

  // neighbour presence follows the cell whose neighbours are now on the read ports
  assign up_mode = (state_r == S_UP);
  assign a_ok    = up_mode ? (row_r != '0) : (col_r != CW'(COLS - 1));
  assign b_ok    = up_mode ? (col_r != '0) : (row_r != RW'(ROWS - 1));

  // two copies of the tableau, written together, so both neighbours are read in the same cycle
  yt_ram #(.WIDTH(KEY_W), .DEPTH(NCELLS)) u_ram_a (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  yt_ram #(.WIDTH(KEY_W), .DEPTH(NCELLS)) u_ram_b (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  yt_step u_step (
    .up_mode (up_mode),
    .key     (key_r),
    .nb_a    (rdata_a),
    .nb_b    (rdata_b),
    .a_ok    (a_ok),
    .b_ok    (b_ok),
    .step    (step)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_r == AW'(NCELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          if (in_op == OP_EXTRACT) begin
            state_nxt = is_empty ? S_DONE : S_HEAD;
          end else if (is_full || in_key == KEY_EMPTY) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_UP;
          end
        end
      end
      S_HEAD: state_nxt = S_DOWN;
      S_UP, S_DOWN: begin
        if (!step.move) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // datapath and memory control
  always_comb begin
    clr_nxt      = clr_r;
    count_nxt    = count_r;
    pos_nxt      = pos_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    key_nxt      = key_r;
    res_min_nxt  = res_min_r;
    res_stat_nxt = res_stat_r;
    ram_we       = 1'b0;
    ram_waddr    = pos_r;
    ram_wdata    = key_r;
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = KEY_EMPTY;
        clr_nxt   = clr_r + AW'(1);
      end
      S_IDLE: begin
        if (in_xfer) begin
          res_min_nxt  = KEY_EMPTY;
          res_stat_nxt = STATUS_OK;
          if (in_op == OP_EXTRACT) begin
            if (is_empty) begin
              res_stat_nxt = STATUS_EMPTY;
            end else begin
              count_nxt = count_r - CNTW'(1);
            end
          end else if (is_full) begin
            res_stat_nxt = STATUS_FULL;
          end else if (in_key != KEY_EMPTY) begin
            // new key starts in the bottom-right cell
            count_nxt = count_r + CNTW'(1);
            pos_nxt   = AW'(NCELLS - 1);
            row_nxt   = RW'(ROWS - 1);
            col_nxt   = CW'(COLS - 1);
            key_nxt   = in_key;
          end
        end
      end
      S_HEAD: begin
        // top-left key has arrived; the marker then sinks from there
        res_min_nxt = rdata_a;
        pos_nxt     = '0;
        row_nxt     = '0;
        col_nxt     = '0;
        key_nxt     = KEY_EMPTY;
      end
      S_UP: begin
        ram_we = 1'b1;
        if (step.move) begin
          ram_wdata = step.value;
          if (step.pick_b) begin
            pos_nxt = pos_r - AW'(1);
            col_nxt = col_r - CW'(1);
          end else begin
            pos_nxt = pos_r - AW'(COLS);
            row_nxt = row_r - RW'(1);
          end
        end
      end
      S_DOWN: begin
        ram_we = 1'b1;
        if (step.move) begin
          ram_wdata = step.value;
          if (step.pick_b) begin
            pos_nxt = pos_r + AW'(COLS);
            row_nxt = row_r + RW'(1);
          end else begin
            pos_nxt = pos_r + AW'(1);
            col_nxt = col_r + CW'(1);
          end
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // read addresses: head fetch, else the neighbours of the next sift cell
  // (never the cell being written in the same cycle)
  always_comb begin
    if (in_xfer && in_op == OP_EXTRACT) begin
      raddr_a = '0;
      raddr_b = '0;
    end else if (state_nxt == S_UP) begin
      raddr_a = pos_nxt - AW'(COLS);
      raddr_b = pos_nxt - AW'(1);
    end else begin
      raddr_a = pos_nxt + AW'(1);
      raddr_b = pos_nxt + AW'(COLS);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      count_r <= count_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    key_r      <= key_nxt;
    res_min_r  <= res_min_nxt;
    res_stat_r <= res_stat_nxt;
    if (load_out) begin
      out_min_r  <= res_min_r;
      out_stat_r <= res_stat_r;
      out_held_r <= HELD_W'(count_r);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_min_value = out_min_r;
  assign out_status    = out_stat_r;
  assign out_held      = out_held_r;

endmodule

// File: tb/tableau_checker.sv
`timescale 1ns / 100ps
// checker for the young tableau priority queue: watches both channels,
// keeps its own copy of the tableau and compares every result. needs yt_pkg

module tableau_checker import yt_pkg::*; #(
  parameter int ROWS = 8,
  parameter int COLS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic                     in_op,
  input  logic signed [KEY_W-1:0]  in_key,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic signed [KEY_W-1:0]  out_min_value,
  input  logic [1:0]               out_status,
  input  logic [HELD_W-1:0]        out_held,
  output int                       pending,
  output int                       mismatches,
  output int                       full_hits,
  output int                       empty_hits
);

  localparam int CELLS = ROWS * COLS;

  typedef struct packed {
    logic signed [KEY_W-1:0] min_value;
    logic [1:0]              status;
    logic [HELD_W-1:0]       held;
  } outcome_t;

  logic signed [KEY_W-1:0] grid [CELLS];
  int                      keys_held;
  outcome_t                awaited_outcomes [$];
  outcome_t                seen, due;
  int                      err_total, full_total, empty_total, idx;

  // new key enters bottom right and moves up/left past larger neighbours
  task automatic sift_in(input logic signed [KEY_W-1:0] k);
    int pos, dst, row, col;
    logic signed [KEY_W-1:0] upv, lfv, best;
    bit moving;
    pos = CELLS - 1;
    moving = 1'b1;
    while (moving) begin
      row = pos / COLS;
      col = pos % COLS;
      upv = (row == 0) ? KEY_MIN : grid[pos - COLS];
      lfv = (col == 0) ? KEY_MIN : grid[pos - 1];
      dst = pos;
      best = k;
      if (k < upv) begin
        dst = pos - COLS;
        best = upv;
      end
      if (best < lfv) dst = pos - 1;
      if (dst == pos) begin
        grid[pos] = k;
        moving = 1'b0;
      end else begin
        grid[pos] = grid[dst];
        pos = dst;
      end
    end
  endtask

  // empty marker enters top left and moves down/right past smaller neighbours
  task automatic sift_out();
    int pos, dst, row, col;
    logic signed [KEY_W-1:0] rtv, dnv, best;
    bit moving;
    pos = 0;
    moving = 1'b1;
    while (moving) begin
      row = pos / COLS;
      col = pos % COLS;
      rtv = (col == COLS - 1) ? KEY_EMPTY : grid[pos + 1];
      dnv = (row == ROWS - 1) ? KEY_EMPTY : grid[pos + COLS];
      dst = pos;
      best = KEY_EMPTY;
      if (KEY_EMPTY > rtv) begin
        dst = pos + 1;
        best = rtv;
      end
      if (best > dnv) dst = pos + COLS;
      if (dst == pos) begin
        grid[pos] = KEY_EMPTY;
        moving = 1'b0;
      end else begin
        grid[pos] = grid[dst];
        pos = dst;
      end
    end
  endtask

  task automatic apply_request(input logic op, input logic signed [KEY_W-1:0] k,
                               output outcome_t res);
    res.min_value = KEY_EMPTY;
    res.status = STATUS_OK;
    if (op == OP_INSERT) begin
      if (keys_held >= CELLS) begin
        res.status = STATUS_FULL;
      end else if (k != KEY_EMPTY) begin
        keys_held++;
        sift_in(k);
      end
    end else begin
      if (keys_held == 0) begin
        res.status = STATUS_EMPTY;
      end else begin
        res.min_value = grid[0];
        sift_out();
        keys_held--;
      end
    end
    res.held = keys_held[HELD_W-1:0];
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (idx = 0; idx < CELLS; idx++) grid[idx] = KEY_EMPTY;
      keys_held = 0;
      awaited_outcomes.delete();
    end else begin
      if (out_valid && out_ready) begin
        seen = '{out_min_value, out_status, out_held};
        if (awaited_outcomes.size() == 0) begin
          err_total++;
          $display("%0t: result with nothing awaited: min %0d status %0d held %0d",
                   $time, seen.min_value, seen.status, seen.held);
        end else begin
          due = awaited_outcomes.pop_front();
          if (seen.min_value !== due.min_value) begin
            err_total++;
            $display("%0t: min_value expected %0d actual %0d",
                     $time, due.min_value, seen.min_value);
          end
          if (seen.status !== due.status) begin
            err_total++;
            $display("%0t: status expected %0d actual %0d", $time, due.status, seen.status);
          end
          if (seen.held !== due.held) begin
            err_total++;
            $display("%0t: held expected %0d actual %0d", $time, due.held, seen.held);
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_request(in_op, in_key, due);
        if (due.status == STATUS_FULL) full_total++;
        if (due.status == STATUS_EMPTY) empty_total++;
        awaited_outcomes.push_back(due);
      end
    end
    pending    <= awaited_outcomes.size();
    mismatches <= err_total;
    full_hits  <= full_total;
    empty_hits <= empty_total;
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// top of the young tableau priority queue testbench: clock, reset, stimulus
// and verdict. needs yt_pkg, tableau_checker and the block itself

module testbench;
  import yt_pkg::*;

  localparam int ROWS         = 8;
  localparam int COLS         = 8;
  localparam int RANDOM_ITEMS = 1430;
  localparam int CALM_ITEMS   = 150;
  // a generous tail for the last result to come back
  localparam int TAIL_CYCLES  = 2 * (ROWS + COLS) + 8;
  // longest honest quiet spell is a sender gap, a sift and a receiver stall
  localparam int STALL_LIMIT  = 2000;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic                     in_op;
  logic signed [KEY_W-1:0]  in_key;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [KEY_W-1:0]  out_min_value;
  logic [1:0]               out_status;
  logic [HELD_W-1:0]        out_held;

  int pending, mismatches, full_hits, empty_hits;
  int n_insert, n_extract, ready_left, quiet_cycles;
  logic calm;

  young_tableau_priority_queue #(.ROWS(ROWS), .COLS(COLS)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op), .in_key(in_key),
    .out_valid(out_valid), .out_ready(out_ready), .out_min_value(out_min_value),
    .out_status(out_status), .out_held(out_held)
  );

  tableau_checker #(.ROWS(ROWS), .COLS(COLS)) check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op), .in_key(in_key),
    .out_valid(out_valid), .out_ready(out_ready), .out_min_value(out_min_value),
    .out_status(out_status), .out_held(out_held),
    .pending(pending), .mismatches(mismatches),
    .full_hits(full_hits), .empty_hits(empty_hits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: stall bursts of random length between runs of ready, a stall
  // is always followed by ready; always ready once the calm tail starts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      ready_left <= 0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else if (ready_left == 0) begin
      if (out_ready && $urandom_range(0, 2) == 0) begin
        out_ready  <= 1'b0;
        ready_left <= $urandom_range(0, 14);
      end else begin
        out_ready  <= 1'b1;
        ready_left <= $urandom_range(0, 29);
      end
    end else begin
      ready_left <= ready_left - 1;
    end
  end

  // watchdog: too many cycles with no transfer on either channel ends the run
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
          $display("testbench: errors");
          $finish;
        end
      end
    end
  end

  // key mix: full-width random, a narrow band for ties, both ends of the range,
  // and now and then the empty marker itself
  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom;
      5, 6, 7:       return $signed($urandom_range(0, 8)) - 4;
      8:             return KEY_MIN + $urandom_range(0, 3);
      default:       return ($urandom_range(0, 19) == 0) ? KEY_EMPTY
                                                         : KEY_EMPTY - 1 - $urandom_range(0, 2);
    endcase
  endfunction

  // one input transfer; valid stays high from one item to the next unless a gap is drawn
  task automatic push_item(input logic op, input logic signed [KEY_W-1:0] key,
                           input int gap_pct);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_key   <= key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == OP_INSERT) n_insert++;
    else n_extract++;
  endtask

  // hold off the sender until every awaited result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_items(input int span, input int ins_pct, input int gap_pct);
    int j;
    for (j = 0; j < span; j++) begin
      push_item(($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_EXTRACT,
                pick_key(), gap_pct);
    end
  endtask

  initial begin
    int sent, span, ins_pct, gap_pct, phase, k;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_op      <= OP_INSERT;
    in_key     <= '0;
    calm       <= 1'b0;
    n_insert   = 0;
    n_extract  = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extract on empty, both key extremes, the marker value, ties
    push_item(OP_EXTRACT, '0, 0);
    push_item(OP_INSERT, KEY_MIN, 0);
    push_item(OP_INSERT, KEY_EMPTY - 1, 0);
    push_item(OP_INSERT, KEY_EMPTY, 0);
    push_item(OP_INSERT, -1, 0);
    push_item(OP_INSERT, 0, 0);
    push_item(OP_INSERT, 7, 0);
    push_item(OP_INSERT, 7, 0);
    push_item(OP_INSERT, 7, 0);
    push_item(OP_INSERT, 3, 0);
    push_item(OP_INSERT, KEY_EMPTY - 1, 0);
    push_item(OP_INSERT, KEY_MIN, 0);
    // empty it out and go one past
    for (k = 0; k < 11; k++) push_item(OP_EXTRACT, $urandom, 0);

    // random phases, each with its own insert/extract balance; the first is
    // insert-heavy so the store fills and refuses
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS - CALM_ITEMS) begin
      span = $urandom_range(40, 120);
      if (span > RANDOM_ITEMS - CALM_ITEMS - sent) span = RANDOM_ITEMS - CALM_ITEMS - sent;
      if (phase == 0) begin
        ins_pct = 85;
      end else begin
        case ($urandom_range(0, 2))
          0:       ins_pct = 85;
          1:       ins_pct = 50;
          default: ins_pct = 15;
        endcase
      end
      gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
      random_items(span, ins_pct, gap_pct);
      sent += span;
      if (phase == 0 || $urandom_range(0, 2) == 0) drain();
      phase++;
    end

    // calm tail: no idling on either side
    calm <= 1'b1;
    random_items(CALM_ITEMS, 50, 0);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d items in %0d phases: %0d inserts, %0d extracts",
             n_insert + n_extract, phase, n_insert, n_extract);
    $display("%0d inserts refused when full, %0d extracts when empty", full_hits, empty_hits);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
